>>> rtl/core/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Types, constants and decode helpers for the 8051 execute subset.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int RamBytes = 128;
  localparam int RamAw    = $clog2(RamBytes);

  localparam logic [7:0] FlagCy = 8'h80;
  localparam logic [7:0] FlagAc = 8'h40;
  localparam logic [7:0] FlagOv = 8'h04;

  localparam logic [7:0] SfrSp  = 8'h81;
  localparam logic [7:0] SfrPsw = 8'hD0;
  localparam logic [7:0] SfrAcc = 8'hE0;

  localparam logic [7:0] OpLjmp  = 8'h02;
  localparam logic [7:0] OpLcall = 8'h12;
  localparam logic [7:0] OpRet   = 8'h22;
  localparam logic [7:0] OpRr    = 8'h03;
  localparam logic [7:0] OpRl    = 8'h23;
  localparam logic [7:0] OpRrc   = 8'h13;
  localparam logic [7:0] OpRlc   = 8'h33;
  localparam logic [7:0] OpClrA  = 8'hE4;
  localparam logic [7:0] OpClrC  = 8'hC3;
  localparam logic [7:0] OpSetbC = 8'hD3;
  localparam logic [7:0] OpClrB  = 8'hC2;
  localparam logic [7:0] OpSetbB = 8'hD2;
  localparam logic [7:0] OpMovCB = 8'hA2;
  localparam logic [7:0] OpMovBC = 8'h92;
  localparam logic [7:0] OpJbc   = 8'h10;
  localparam logic [7:0] OpJb    = 8'h20;
  localparam logic [7:0] OpPush  = 8'hC0;

  localparam logic [3:0] HiAdd = 4'h2;
  localparam logic [3:0] HiOrl = 4'h4;
  localparam logic [3:0] HiAnl = 4'h5;
  localparam logic [3:0] HiXrl = 4'h6;
  localparam logic [3:0] HiMov = 4'h7;

  typedef enum logic [4:0] {
    CL_AJMP, CL_INCDEC, CL_ALU, CL_DIRLOG, CL_MOVI, CL_LJMP, CL_LCALL, CL_RET,
    CL_RR, CL_RL, CL_RRC, CL_RLC, CL_CLRA, CL_CLRC, CL_SETBC, CL_CLRB,
    CL_SETBB, CL_MOVCB, CL_MOVBC, CL_JBC, CL_JB, CL_PUSH, CL_BAD
  } cls_e;

  typedef enum logic [2:0] {
    S_IDLE, S_PTR, S_RD, S_RD2, S_EXE, S_WR2
  } state_e;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand_one;
    logic [7:0] operand_two;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  accumulator;
    logic [7:0]  status_word;
    logic        outcome;
  } out_item_t;

  function automatic cls_e decode(logic [7:0] op);
    logic [3:0] hi;
    logic [3:0] lo;
    cls_e       c;
    hi = op[7:4];
    lo = op[3:0];
    priority if (op[4:0] == 5'h11 || op[4:0] == 5'h01) begin
      c = CL_AJMP;
    end else if (hi <= 4'h1 && lo >= 4'h4) begin
      c = CL_INCDEC;
    end else if ((hi == HiAdd || hi == HiOrl || hi == HiAnl || hi == HiXrl) &&
                 lo >= 4'h4) begin
      c = CL_ALU;
    end else if ((hi == HiOrl || hi == HiAnl || hi == HiXrl) &&
                 (lo == 4'h2 || lo == 4'h3)) begin
      c = CL_DIRLOG;
    end else if (hi == HiMov && lo >= 4'h4 && lo != 4'h5) begin
      c = CL_MOVI;
    end else begin
      unique case (op)
        OpLjmp:  c = CL_LJMP;
        OpLcall: c = CL_LCALL;
        OpRet:   c = CL_RET;
        OpRr:    c = CL_RR;
        OpRl:    c = CL_RL;
        OpRrc:   c = CL_RRC;
        OpRlc:   c = CL_RLC;
        OpClrA:  c = CL_CLRA;
        OpClrC:  c = CL_CLRC;
        OpSetbC: c = CL_SETBC;
        OpClrB:  c = CL_CLRB;
        OpSetbB: c = CL_SETBB;
        OpMovCB: c = CL_MOVCB;
        OpMovBC: c = CL_MOVBC;
        OpJbc:   c = CL_JBC;
        OpJb:    c = CL_JB;
        OpPush:  c = CL_PUSH;
        default: c = CL_BAD;
      endcase
    end
    return c;
  endfunction

  // @Ri forms need the pointer fetched from the register bank first
  function automatic logic uses_ptr(logic [7:0] op);
    cls_e c;
    c = decode(op);
    return (c == CL_INCDEC || c == CL_ALU || c == CL_MOVI) && (op[3:1] == 3'b011);
  endfunction

  function automatic logic in_ram(logic [7:0] a);
    return ({1'b0, a} < 9'(RamBytes));
  endfunction

endpackage

>>> rtl/core/mcs51_instruction_execute_subset.sv
// ----------------------------------------------------------------------------
// mcs51_instruction_execute_subset
// Executes one 8051 instruction per item against PC, A, PSW, SP and data RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, in_data_i) takes opcode plus the two
// following code bytes. Output channel (out_valid_o/out_ready_i, out_data_o)
// returns PC, A and PSW after the instruction and an unsupported flag.
// All architectural state but the RAM is in flops; the RAM is one
// single-port synchronous array, one access per cycle, read data registered.
// Each item passes an operand read state (S_RD) and an execute/write back
// state (S_EXE). @Ri forms add a pointer fetch (S_PTR) before the read,
// RET adds a second stack read (S_RD2), and ACALL/LCALL add a second stack
// write (S_WR2). The RAM port sets these steps. A new item is taken in
// the cycle an instruction commits, so sequences run back to back.
// The result sits in an output register; the result appears the cycle after
// commit. If the receiver stalls, the next item is still accepted and runs
// up to its operand read, where it waits until the output register frees.
// Reset: PC=0, A=0, PSW=0, SP=7. RAM reads zero until written (per-byte
// valid flags, cleared at reset), so no clearing pass is needed.
// ----------------------------------------------------------------------------
module mcs51_instruction_execute_subset (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mcs_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mcs_pkg::out_item_t   out_data_o
);

  mcs_pkg::state_e state_q, state_d;

  logic [7:0]  op_q, o1_q, o2_q;
  logic [15:0] pc_q, pc_d;
  logic [7:0]  a_q, a_d, psw_q, psw_d, sp_q, sp_d;
  logic [7:0]  ea_q, ea_d;
  logic        ea_ram_q, ea_ram_d;
  logic [7:0]  hold_q, hold_d;
  logic        hold_en;

  logic [7:0]  mem [mcs_pkg::RamBytes];
  logic [mcs_pkg::RamBytes-1:0] valid_q;
  logic [7:0]  rd_q;
  logic        rd_hit_q;
  logic        mem_re, mem_we;
  logic [7:0]  mem_ra, mem_wa, mem_wd;
  logic [7:0]  rdata;

  mcs_pkg::out_item_t out_q;
  logic        out_valid_q;

  mcs_pkg::cls_e cls;
  logic        is_call, fin, accept, out_free, ok;
  logic [1:0]  bank;

  assign cls      = mcs_pkg::decode(op_q);
  assign is_call  = (cls == mcs_pkg::CL_AJMP && op_q[4]) || cls == mcs_pkg::CL_LCALL;
  assign fin      = (state_q == mcs_pkg::S_EXE && !is_call) || state_q == mcs_pkg::S_WR2;
  assign in_ready_o = (state_q == mcs_pkg::S_IDLE) || fin;
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign bank     = psw_q[4:3];
  assign rdata    = rd_hit_q ? rd_q : 8'h00;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcs_pkg::S_IDLE: begin
        if (accept) state_d = mcs_pkg::uses_ptr(in_data_i.opcode) ? mcs_pkg::S_PTR
                                                                  : mcs_pkg::S_RD;
      end
      mcs_pkg::S_PTR: state_d = mcs_pkg::S_RD;
      mcs_pkg::S_RD: begin
        if (out_free) state_d = (cls == mcs_pkg::CL_RET) ? mcs_pkg::S_RD2 : mcs_pkg::S_EXE;
      end
      mcs_pkg::S_RD2: state_d = mcs_pkg::S_EXE;
      mcs_pkg::S_EXE, mcs_pkg::S_WR2: begin
        if (state_q == mcs_pkg::S_EXE && is_call) begin
          state_d = mcs_pkg::S_WR2;
        end else if (accept) begin
          state_d = mcs_pkg::uses_ptr(in_data_i.opcode) ? mcs_pkg::S_PTR : mcs_pkg::S_RD;
        end else begin
          state_d = mcs_pkg::S_IDLE;
        end
      end
      default: state_d = mcs_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM port
  always_comb begin
    logic [3:0]  lo;
    logic [7:0]  opnd, s, v, bmask, loc_v;
    logic        loc_we, bitv, cy;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [15:0] ret, npc2;

    lo     = op_q[3:0];
    pc_d   = pc_q;
    a_d    = a_q;
    psw_d  = psw_q;
    sp_d   = sp_q;
    ea_d   = ea_q;
    ea_ram_d = ea_ram_q;
    hold_d = hold_q;
    hold_en = 1'b0;
    mem_re = 1'b0;
    mem_ra = 8'h00;
    mem_we = 1'b0;
    mem_wa = 8'h00;
    mem_wd = 8'h00;
    ok     = 1'b1;
    loc_we = 1'b0;
    loc_v  = 8'h00;
    s      = 8'h00;
    v      = 8'h00;
    sum9   = 9'h000;
    nib    = 5'h00;
    ret    = 16'h0000;
    npc2   = 16'h0000;
    bmask  = 8'b1 << o1_q[2:0];
    cy     = psw_q[7];

    unique case (ea_q)
      mcs_pkg::SfrSp:  opnd = sp_q;
      mcs_pkg::SfrPsw: opnd = psw_q;
      mcs_pkg::SfrAcc: opnd = a_q;
      default:         opnd = 8'h00;
    endcase
    if (ea_ram_q) opnd = rdata;
    bitv = opnd[o1_q[2:0]];

    unique case (state_q)
      mcs_pkg::S_PTR: begin
        mem_re = 1'b1;
        mem_ra = {3'b000, bank, 2'b00, op_q[0]};
      end
      mcs_pkg::S_RD: begin
        unique case (cls)
          mcs_pkg::CL_INCDEC, mcs_pkg::CL_ALU, mcs_pkg::CL_MOVI: begin
            priority if (lo == 4'h4) begin
              ea_d = mcs_pkg::SfrAcc;
              ea_ram_d = 1'b0;
            end else if (lo == 4'h5) begin
              ea_d = o1_q;
              ea_ram_d = !o1_q[7];
            end else if (lo < 4'h8) begin
              ea_d = rdata;
              ea_ram_d = 1'b1;
            end else begin
              ea_d = {3'b000, bank, op_q[2:0]};
              ea_ram_d = 1'b1;
            end
          end
          mcs_pkg::CL_DIRLOG, mcs_pkg::CL_PUSH: begin
            ea_d = o1_q;
            ea_ram_d = !o1_q[7];
          end
          mcs_pkg::CL_CLRB, mcs_pkg::CL_SETBB, mcs_pkg::CL_MOVCB, mcs_pkg::CL_MOVBC,
          mcs_pkg::CL_JBC, mcs_pkg::CL_JB: begin
            ea_d = o1_q[7] ? {o1_q[7:3], 3'b000} : {4'b0010, o1_q[6:3]};
            ea_ram_d = !o1_q[7];
          end
          mcs_pkg::CL_RET: begin
            ea_d = sp_q;
            ea_ram_d = 1'b1;
          end
          default: begin
            ea_d = o1_q;
            ea_ram_d = 1'b0;
          end
        endcase
        // hold the pointer data while stalled: no read until we advance
        mem_re = out_free && ea_ram_d;
        mem_ra = ea_d;
      end
      mcs_pkg::S_RD2: begin
        hold_en = 1'b1;
        hold_d  = rdata;
        mem_ra  = sp_q - 8'd1;
        mem_re  = 1'b1;
      end
      mcs_pkg::S_EXE: begin
        unique case (cls)
          mcs_pkg::CL_AJMP: begin
            npc2 = pc_q + 16'd2;
            pc_d = {npc2[15:11], op_q[7:5], o1_q};
            ret  = npc2;
          end
          mcs_pkg::CL_LCALL: begin
            ret  = pc_q + 16'd3;
            pc_d = {o1_q, o2_q};
          end
          mcs_pkg::CL_LJMP: pc_d = {o1_q, o2_q};
          mcs_pkg::CL_INCDEC: begin
            loc_we = 1'b1;
            loc_v  = op_q[4] ? opnd - 8'd1 : opnd + 8'd1;
            pc_d   = pc_q + ((lo == 4'h5) ? 16'd2 : 16'd1);
          end
          mcs_pkg::CL_ALU: begin
            s = (lo == 4'h4) ? o1_q : opnd;
            unique case (op_q[7:4])
              mcs_pkg::HiAdd: begin
                sum9 = {1'b0, a_q} + {1'b0, s};
                nib  = {1'b0, a_q[3:0]} + {1'b0, s[3:0]};
                psw_d = psw_q & ~(mcs_pkg::FlagCy | mcs_pkg::FlagAc | mcs_pkg::FlagOv);
                if (sum9[8]) psw_d = psw_d | mcs_pkg::FlagCy;
                if (nib[4]) psw_d = psw_d | mcs_pkg::FlagAc;
                if ((a_q[7] ^ sum9[7]) & (s[7] ^ sum9[7])) psw_d = psw_d | mcs_pkg::FlagOv;
                a_d = sum9[7:0];
              end
              mcs_pkg::HiOrl: a_d = a_q | s;
              mcs_pkg::HiAnl: a_d = a_q & s;
              default:        a_d = a_q ^ s;
            endcase
            pc_d = pc_q + ((lo <= 4'h5) ? 16'd2 : 16'd1);
          end
          mcs_pkg::CL_DIRLOG: begin
            s = (lo == 4'h2) ? a_q : o2_q;
            unique case (op_q[7:4])
              mcs_pkg::HiOrl: v = opnd | s;
              mcs_pkg::HiAnl: v = opnd & s;
              default:        v = opnd ^ s;
            endcase
            loc_we = 1'b1;
            loc_v  = v;
            pc_d   = pc_q + ((lo == 4'h2) ? 16'd2 : 16'd3);
          end
          mcs_pkg::CL_MOVI: begin
            loc_we = 1'b1;
            loc_v  = o1_q;
            pc_d   = pc_q + 16'd2;
          end
          mcs_pkg::CL_RET: begin
            pc_d = {hold_q, rdata};
            sp_d = sp_q - 8'd2;
          end
          mcs_pkg::CL_RR: begin
            a_d = {a_q[0], a_q[7:1]};
            pc_d = pc_q + 16'd1;
          end
          mcs_pkg::CL_RL: begin
            a_d = {a_q[6:0], a_q[7]};
            pc_d = pc_q + 16'd1;
          end
          mcs_pkg::CL_RRC: begin
            a_d = {cy, a_q[7:1]};
            psw_d = {a_q[0], psw_q[6:0]};
            pc_d = pc_q + 16'd1;
          end
          mcs_pkg::CL_RLC: begin
            a_d = {a_q[6:0], cy};
            psw_d = {a_q[7], psw_q[6:0]};
            pc_d = pc_q + 16'd1;
          end
          mcs_pkg::CL_CLRA: begin
            a_d = 8'h00;
            pc_d = pc_q + 16'd1;
          end
          mcs_pkg::CL_CLRC: begin
            psw_d = psw_q & ~mcs_pkg::FlagCy;
            pc_d = pc_q + 16'd1;
          end
          mcs_pkg::CL_SETBC: begin
            psw_d = psw_q | mcs_pkg::FlagCy;
            pc_d = pc_q + 16'd1;
          end
          mcs_pkg::CL_CLRB, mcs_pkg::CL_SETBB, mcs_pkg::CL_MOVBC: begin
            loc_we = 1'b1;
            priority if (cls == mcs_pkg::CL_SETBB ||
                         (cls == mcs_pkg::CL_MOVBC && cy)) begin
              loc_v = opnd | bmask;
            end else begin
              loc_v = opnd & ~bmask;
            end
            pc_d = pc_q + 16'd2;
          end
          mcs_pkg::CL_MOVCB: begin
            psw_d = {bitv, psw_q[6:0]};
            pc_d = pc_q + 16'd2;
          end
          mcs_pkg::CL_JBC, mcs_pkg::CL_JB: begin
            pc_d = pc_q + 16'd3;
            if (bitv) begin
              pc_d = pc_q + 16'd3 + {{8{o2_q[7]}}, o2_q};
              if (cls == mcs_pkg::CL_JBC) begin
                loc_we = 1'b1;
                loc_v  = opnd & ~bmask;
              end
            end
          end
          mcs_pkg::CL_PUSH: begin
            sp_d   = sp_q + 8'd1;
            mem_wa = sp_d;
            // PUSH SP stores the already incremented pointer
            mem_wd = (!ea_ram_q && ea_q == mcs_pkg::SfrSp) ? sp_d : opnd;
            mem_we = mcs_pkg::in_ram(mem_wa);
            pc_d   = pc_q + 16'd2;
          end
          default: ok = 1'b0;
        endcase
        if (is_call) begin
          // low byte of the return address now, high byte next cycle
          sp_d    = sp_q + 8'd1;
          mem_wa  = sp_d;
          mem_wd  = ret[7:0];
          mem_we  = mcs_pkg::in_ram(mem_wa);
          hold_en = 1'b1;
          hold_d  = ret[15:8];
        end
        if (loc_we) begin
          if (ea_ram_q) begin
            mem_wa = ea_q;
            mem_wd = loc_v;
            mem_we = mcs_pkg::in_ram(ea_q);
          end else begin
            unique case (ea_q)
              mcs_pkg::SfrSp:  sp_d  = loc_v;
              mcs_pkg::SfrPsw: psw_d = loc_v;
              mcs_pkg::SfrAcc: a_d   = loc_v;
              default: ;
            endcase
          end
        end
      end
      mcs_pkg::S_WR2: begin
        sp_d   = sp_q + 8'd1;
        mem_wa = sp_d;
        mem_wd = hold_q;
        mem_we = mcs_pkg::in_ram(mem_wa);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcs_pkg::S_IDLE;
      pc_q        <= 16'h0000;
      a_q         <= 8'h00;
      psw_q       <= 8'h00;
      sp_q        <= 8'h07;
      valid_q     <= '0;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      a_q     <= a_d;
      psw_q   <= psw_d;
      sp_q    <= sp_d;
      if (mem_we) valid_q[mem_wa[mcs_pkg::RamAw-1:0]] <= 1'b1;
      // addresses past the RAM read as zero
      if (mem_re) begin
        rd_hit_q <= mcs_pkg::in_ram(mem_ra) && valid_q[mem_ra[mcs_pkg::RamAw-1:0]];
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa[mcs_pkg::RamAw-1:0]] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra[mcs_pkg::RamAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_data_i.opcode;
      o1_q <= in_data_i.operand_one;
      o2_q <= in_data_i.operand_two;
    end
    if (state_q == mcs_pkg::S_RD) begin
      ea_q     <= ea_d;
      ea_ram_q <= ea_ram_d;
    end
    if (hold_en) hold_q <= hold_d;
    if (fin) begin
      out_q.next_pc     <= pc_d;
      out_q.accumulator <= a_d;
      out_q.status_word <= psw_d;
      out_q.outcome     <= !ok;
    end
  end

`ifndef ASSERT_OFF
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcs_pkg::S_EXE |-> !out_valid_q)
    else $error("commit with output register occupied");

  a_unsupported_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && !ok) |-> (pc_d == pc_q && a_d == a_q && psw_d == psw_q &&
                      sp_d == sp_q && !mem_we))
    else $error("unsupported opcode changed state");

  a_ret_second_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcs_pkg::S_RD2 |=> state_q == mcs_pkg::S_EXE)
    else $error("second stack read not followed by execute");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed 8051 instructions into the execute subset and
// compares PC, A, PSW and the unsupported flag against an in-bench ISA model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MaxCycles = 200000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  mcs_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  mcs_pkg::out_item_t out_data_o;

  mcs51_instruction_execute_subset DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // ISA state of the predictor
  logic [15:0] isa_pc;
  logic [7:0]  isa_acc;
  logic [7:0]  isa_psw;
  logic [7:0]  isa_sp;
  logic [7:0]  isa_ram [mcs_pkg::RamBytes];

  mcs_pkg::in_item_t  instr_q [$];
  mcs_pkg::out_item_t exec_q [$];
  int        errors;
  int        cycles;
  int        hold_cycles;
  bit        stim_done;

  function automatic logic [7:0] ram_get(logic [7:0] a);
    return mcs_pkg::in_ram(a) ? isa_ram[a[mcs_pkg::RamAw-1:0]] : 8'h00;
  endfunction

  function automatic void ram_set(logic [7:0] a, logic [7:0] v);
    if (mcs_pkg::in_ram(a)) isa_ram[a[mcs_pkg::RamAw-1:0]] = v;
  endfunction

  function automatic logic [7:0] sfr_get(logic [7:0] a);
    if (a < 8'h80) return isa_ram[a[6:0]];
    if (a == mcs_pkg::SfrSp) return isa_sp;
    if (a == mcs_pkg::SfrPsw) return isa_psw;
    if (a == mcs_pkg::SfrAcc) return isa_acc;
    return 8'h00;
  endfunction

  function automatic void sfr_set(logic [7:0] a, logic [7:0] v);
    if (a < 8'h80) isa_ram[a[6:0]] = v;
    else if (a == mcs_pkg::SfrSp) isa_sp = v;
    else if (a == mcs_pkg::SfrPsw) isa_psw = v;
    else if (a == mcs_pkg::SfrAcc) isa_acc = v;
  endfunction

  function automatic logic [7:0] bank_reg(logic [2:0] n);
    return {3'b000, isa_psw[4:3], n};
  endfunction

  // bit 8 set: indirect RAM address, else direct address
  function automatic logic [8:0] operand_loc(logic [7:0] op, logic [7:0] o1);
    if (op[3:0] == 4'h4) return {1'b0, mcs_pkg::SfrAcc};
    if (op[3:0] == 4'h5) return {1'b0, o1};
    if (op[3:0] < 4'h8) return {1'b1, ram_get(bank_reg({2'b00, op[0]}))};
    return {1'b1, bank_reg(op[2:0])};
  endfunction

  function automatic logic [7:0] loc_get(logic [8:0] l);
    return l[8] ? ram_get(l[7:0]) : sfr_get(l[7:0]);
  endfunction

  function automatic void loc_set(logic [8:0] l, logic [7:0] v);
    if (l[8]) ram_set(l[7:0], v);
    else sfr_set(l[7:0], v);
  endfunction

  function automatic logic [7:0] bit_home(logic [7:0] b);
    return b < 8'h80 ? 8'h20 + {3'b000, b[7:3]} : {b[7:3], 3'b000};
  endfunction

  function automatic logic bit_get(logic [7:0] b);
    logic [7:0] x;
    x = sfr_get(bit_home(b));
    return x[b[2:0]];
  endfunction

  function automatic void bit_set(logic [7:0] b, logic v);
    logic [7:0] x;
    x = sfr_get(bit_home(b));
    x[b[2:0]] = v;
    sfr_set(bit_home(b), x);
  endfunction

  function automatic void stack_push(logic [7:0] v);
    isa_sp = isa_sp + 8'd1;
    ram_set(isa_sp, v);
  endfunction

  function automatic mcs_pkg::out_item_t execute_instr(mcs_pkg::in_item_t it);
    logic [7:0]  op, o1, o2, a, s, v, hb, lb;
    logic [3:0]  hi, lo;
    logic [15:0] npc;
    logic [8:0]  l, sum;
    logic        ok, c;
    mcs_pkg::out_item_t r;
    op = it.opcode; o1 = it.operand_one; o2 = it.operand_two;
    hi = op[7:4]; lo = op[3:0];
    npc = isa_pc; ok = 1'b1;
    if (op[4:0] == 5'h11 || op[4:0] == 5'h01) begin
      npc = isa_pc + 16'd2;
      if (op[4]) begin
        stack_push(npc[7:0]);
        stack_push(npc[15:8]);
      end
      npc = {npc[15:11], op[7:5], o1};
    end else if (hi <= 4'h1 && lo >= 4'h4) begin
      l = operand_loc(op, o1);
      v = loc_get(l);
      loc_set(l, hi != 0 ? v - 8'd1 : v + 8'd1);
      npc = isa_pc + (lo == 4'h5 ? 16'd2 : 16'd1);
    end else if ((hi == mcs_pkg::HiAdd || hi == mcs_pkg::HiOrl || hi == mcs_pkg::HiAnl ||
                  hi == mcs_pkg::HiXrl) && lo >= 4'h4) begin
      a = isa_acc;
      s = (lo == 4'h4) ? o1 : loc_get(operand_loc(op, o1));
      if (hi == mcs_pkg::HiAdd) begin
        sum = {1'b0, a} + {1'b0, s};
        v = sum[7:0];
        isa_psw = isa_psw & ~(mcs_pkg::FlagCy | mcs_pkg::FlagAc | mcs_pkg::FlagOv);
        if (sum[8]) isa_psw = isa_psw | mcs_pkg::FlagCy;
        if (({1'b0, a[3:0]} + {1'b0, s[3:0]}) > 5'd15) isa_psw = isa_psw | mcs_pkg::FlagAc;
        if (((a ^ v) & (s ^ v) & 8'h80) != 0) isa_psw = isa_psw | mcs_pkg::FlagOv;
        isa_acc = v;
      end else if (hi == mcs_pkg::HiOrl) isa_acc = a | s;
      else if (hi == mcs_pkg::HiAnl) isa_acc = a & s;
      else isa_acc = a ^ s;
      npc = isa_pc + (lo <= 4'h5 ? 16'd2 : 16'd1);
    end else if ((hi == mcs_pkg::HiOrl || hi == mcs_pkg::HiAnl || hi == mcs_pkg::HiXrl) &&
                 (lo == 4'h2 || lo == 4'h3)) begin
      v = sfr_get(o1);
      s = (lo == 4'h2) ? isa_acc : o2;
      if (hi == mcs_pkg::HiOrl) v = v | s;
      else if (hi == mcs_pkg::HiAnl) v = v & s;
      else v = v ^ s;
      sfr_set(o1, v);
      npc = isa_pc + (lo == 4'h2 ? 16'd2 : 16'd3);
    end else if (hi == mcs_pkg::HiMov && lo >= 4'h4 && lo != 4'h5) begin
      loc_set(operand_loc(op, o1), o1);
      npc = isa_pc + 16'd2;
    end else begin
      case (op)
        mcs_pkg::OpLjmp: npc = {o1, o2};
        mcs_pkg::OpLcall: begin
          npc = isa_pc + 16'd3;
          stack_push(npc[7:0]);
          stack_push(npc[15:8]);
          npc = {o1, o2};
        end
        mcs_pkg::OpRet: begin
          hb = ram_get(isa_sp); isa_sp = isa_sp - 8'd1;
          lb = ram_get(isa_sp); isa_sp = isa_sp - 8'd1;
          npc = {hb, lb};
        end
        mcs_pkg::OpRr: begin
          isa_acc = {isa_acc[0], isa_acc[7:1]}; npc = isa_pc + 16'd1;
        end
        mcs_pkg::OpRl: begin
          isa_acc = {isa_acc[6:0], isa_acc[7]}; npc = isa_pc + 16'd1;
        end
        mcs_pkg::OpRrc: begin
          c = isa_psw[7];
          isa_psw[7] = isa_acc[0];
          isa_acc = {c, isa_acc[7:1]};
          npc = isa_pc + 16'd1;
        end
        mcs_pkg::OpRlc: begin
          c = isa_psw[7];
          isa_psw[7] = isa_acc[7];
          isa_acc = {isa_acc[6:0], c};
          npc = isa_pc + 16'd1;
        end
        mcs_pkg::OpClrA: begin isa_acc = 8'h00; npc = isa_pc + 16'd1; end
        mcs_pkg::OpClrC: begin isa_psw[7] = 1'b0; npc = isa_pc + 16'd1; end
        mcs_pkg::OpSetbC: begin isa_psw[7] = 1'b1; npc = isa_pc + 16'd1; end
        mcs_pkg::OpClrB: begin bit_set(o1, 1'b0); npc = isa_pc + 16'd2; end
        mcs_pkg::OpSetbB: begin bit_set(o1, 1'b1); npc = isa_pc + 16'd2; end
        mcs_pkg::OpMovCB: begin isa_psw[7] = bit_get(o1); npc = isa_pc + 16'd2; end
        mcs_pkg::OpMovBC: begin bit_set(o1, isa_psw[7]); npc = isa_pc + 16'd2; end
        mcs_pkg::OpJbc, mcs_pkg::OpJb: begin
          npc = isa_pc + 16'd3;
          if (bit_get(o1)) begin
            if (op == mcs_pkg::OpJbc) bit_set(o1, 1'b0);
            npc = npc + {{8{o2[7]}}, o2};
          end
        end
        mcs_pkg::OpPush: begin
          // SP moves first, so PUSH SP stores the new value
          isa_sp = isa_sp + 8'd1;
          v = sfr_get(o1);
          ram_set(isa_sp, v);
          npc = isa_pc + 16'd2;
        end
        default: ok = 1'b0;
      endcase
    end
    if (ok) isa_pc = npc;
    r.next_pc = isa_pc;
    r.accumulator = isa_acc;
    r.status_word = isa_psw;
    r.outcome = ~ok;
    return r;
  endfunction

  function automatic mcs_pkg::in_item_t mk(logic [7:0] op, logic [7:0] o1, logic [7:0] o2);
    mcs_pkg::in_item_t it;
    it.opcode = op; it.operand_one = o1; it.operand_two = o2;
    return it;
  endfunction

  // bit addresses: RAM bits, ACC, PSW, bits of SFR 80h (no storage here), or junk
  function automatic logic [7:0] rand_bit();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 8'($urandom_range(0, 127));
    if (k == 5) return {5'b11100, 3'($urandom)};
    if (k == 6) return {5'b11010, 3'($urandom)};
    if (k == 7) return {5'b10000, 3'($urandom)};
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] rand_dir();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 8'($urandom_range(0, 127));
    if (k == 6) return mcs_pkg::SfrAcc;
    if (k == 7) return mcs_pkg::SfrPsw;
    if (k == 8) return mcs_pkg::SfrSp;
    return 8'($urandom);
  endfunction

  function automatic mcs_pkg::in_item_t rand_instr();
    logic [7:0] op, o1, o2;
    int k;
    k = $urandom_range(0, 19);
    op = 8'($urandom); o1 = 8'($urandom); o2 = 8'($urandom);
    case (k)
      0, 1: op = {4'($urandom_range(0, 1)), 4'($urandom_range(4, 15))};
      2, 3, 4: op = {4'($urandom_range(0, 3)) == 0 ? mcs_pkg::HiAdd :
                     4'($urandom_range(4, 6)), 4'($urandom_range(4, 15))};
      5: op = {4'($urandom_range(4, 6)), 4'($urandom_range(2, 3))};
      6: op = {mcs_pkg::HiMov, 4'($urandom_range(6, 15))};
      7: op = 8'h74;
      8: begin
        op = 8'h75; // MOV direct,#imm is unsupported here
      end
      9: op = mcs_pkg::OpRet;
      10: op = mcs_pkg::OpLcall;
      11: op = {3'($urandom), 5'h11};
      12: op = mcs_pkg::OpPush;
      13: begin
        op = $urandom_range(0, 1) ? mcs_pkg::OpJb : mcs_pkg::OpJbc;
        o1 = rand_bit();
      end
      14: begin
        case ($urandom_range(0, 3))
          0: op = mcs_pkg::OpClrB;
          1: op = mcs_pkg::OpSetbB;
          2: op = mcs_pkg::OpMovCB;
          default: op = mcs_pkg::OpMovBC;
        endcase
        o1 = rand_bit();
      end
      15: case ($urandom_range(0, 6))
        0: op = mcs_pkg::OpRr;
        1: op = mcs_pkg::OpRl;
        2: op = mcs_pkg::OpRrc;
        3: op = mcs_pkg::OpRlc;
        4: op = mcs_pkg::OpClrA;
        5: op = mcs_pkg::OpClrC;
        default: op = mcs_pkg::OpSetbC;
      endcase
      16: op = $urandom_range(0, 1) ? mcs_pkg::OpLjmp : {3'($urandom), 5'h01};
      default: ;
    endcase
    if (k == 5 || k == 12 || (k <= 4 && op[3:0] == 4'h5)) o1 = rand_dir();
    return mk(op, o1, o2);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    isa_pc = '0; isa_acc = '0; isa_psw = '0; isa_sp = 8'd7;
    foreach (isa_ram[i]) isa_ram[i] = '0;
    // directed: flags, banks, indirection, stack, bit space, unsupported
    instr_q.push_back(mk(8'h74, 8'hFF, 8'h00));         // MOV A,#FF
    instr_q.push_back(mk(8'h24, 8'h01, 8'h00));         // ADD: C, AC
    instr_q.push_back(mk(8'h74, 8'h7F, 8'h00));
    instr_q.push_back(mk(8'h24, 8'h01, 8'h00));         // ADD: OV
    instr_q.push_back(mk(8'h24, 8'h80, 8'hFF));
    instr_q.push_back(mk(mcs_pkg::OpSetbB, 8'hD3, 8'h00)); // bank 1 via PSW bit
    instr_q.push_back(mk(8'h78, 8'h30, 8'h00));         // MOV R0,#30
    instr_q.push_back(mk(8'h76, 8'hA5, 8'h00));         // MOV @R0,#A5
    instr_q.push_back(mk(8'h26, 8'h00, 8'h00));         // ADD A,@R0
    instr_q.push_back(mk(8'h79, 8'hF0, 8'h00));         // R1 = F0: above RAM
    instr_q.push_back(mk(8'h77, 8'h55, 8'h00));
    instr_q.push_back(mk(8'h07, 8'h00, 8'h00));
    instr_q.push_back(mk(8'h42, 8'hE0, 8'h00));         // ORL ACC,A
    instr_q.push_back(mk(8'h63, 8'h81, 8'hFF));         // XRL SP,#FF
    instr_q.push_back(mk(8'h53, 8'h81, 8'h07));         // ANL SP,#07
    instr_q.push_back(mk(mcs_pkg::OpLcall, 8'hFF, 8'hFF));
    instr_q.push_back(mk(8'hF1, 8'h00, 8'h00));         // ACALL at top page
    instr_q.push_back(mk(mcs_pkg::OpRet, 8'h00, 8'h00));
    instr_q.push_back(mk(mcs_pkg::OpRet, 8'h00, 8'h00));
    instr_q.push_back(mk(mcs_pkg::OpPush, mcs_pkg::SfrPsw, 8'h00));
    instr_q.push_back(mk(mcs_pkg::OpPush, mcs_pkg::SfrSp, 8'h00));
    instr_q.push_back(mk(mcs_pkg::OpSetbB, 8'h00, 8'h00));
    instr_q.push_back(mk(mcs_pkg::OpJbc, 8'h00, 8'h80));   // taken, backward
    instr_q.push_back(mk(mcs_pkg::OpJb, 8'h00, 8'h7F));    // not taken
    instr_q.push_back(mk(8'hA5, 8'h00, 8'h00));         // unsupported
    instr_q.push_back(mk(mcs_pkg::OpRlc, 8'h00, 8'h00));
    for (int i = 0; i < 550; i++) instr_q.push_back(rand_instr());
  end

  // driver
  int gap;
  initial begin
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        exec_q.push_back(execute_instr(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          gap <= gap - 1;
        end else if (instr_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= instr_q.pop_front();
          gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
        end else begin
          in_valid_i <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor and receiver stalls
  int stall;
  initial begin
    out_ready_i = 1'b0; errors = 0; gap = 0; stall = 0; hold_cycles = 0;
    stim_done = 1'b0; cycles = 0;
  end

  always @(posedge clk_i) begin
    mcs_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (exec_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected item: %h", out_data_o);
        end else begin
          want = exec_q.pop_front();
          if (want !== out_data_o) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("pc %h/%h a %h/%h psw %h/%h bad %b/%b (exp/got)",
                       want.next_pc, out_data_o.next_pc, want.accumulator,
                       out_data_o.accumulator, want.status_word,
                       out_data_o.status_word, want.outcome, out_data_o.outcome);
          end
        end
      end
      // one long hold-off early on to back the block up
      if (hold_cycles < 60 && exec_q.size() > 0) begin
        hold_cycles <= hold_cycles + 1;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_ready_i <= 1'b0;
      end else if (!out_ready_i || out_valid_o) begin
        if ($urandom_range(0, 3) == 0) begin
          stall <= $urandom_range(0, 11);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    @(posedge stim_done);
    while (exec_q.size() > 0 && cycles < MaxCycles) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (cycles >= MaxCycles) begin
      $display("mcs51_instruction_execute_subset: mismatch");
    end else if (errors == 0 && exec_q.size() == 0) begin
      $display("mcs51_instruction_execute_subset: match");
    end else begin
      $display("mcs51_instruction_execute_subset: mismatch");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MaxCycles + 100) begin
      $display("mcs51_instruction_execute_subset: mismatch");
      $finish;
    end
  end

endmodule
